// ===== rtl/core/gpdr_pkg.sv =====
`default_nettype none

package gpdr_pkg;

  localparam int unsigned FieldBits = 8;
  localparam int unsigned ModBits   = FieldBits + 1;
  localparam int unsigned IdxBits   = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_NOT_INV  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CHECK,
    S_INV,
    S_QRD,
    S_QST,
    S_QMUL,
    S_RRD,
    S_RST,
    S_RMUL,
    S_ORD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [FieldBits-1:0] dividend_coeff;
    logic [FieldBits-1:0] divisor_coeff;
    logic                 last;
  } in_beat_t;

  typedef struct packed {
    logic [IdxBits-1:0]   coeff_index;
    logic [FieldBits-1:0] quot_coeff;
    logic [FieldBits-1:0] rem_coeff;
    status_e              status;
    logic                 last_out;
  } out_beat_t;

  // Shifts one bit into a reduced residue and reduces it again.
  function automatic logic [ModBits-1:0] red_shift(input logic [ModBits-1:0] r,
                                                   input logic               b,
                                                   input logic [ModBits-1:0] m,
                                                   input logic [ModBits-1:0] mtop);
    logic [ModBits-1:0] t;
    t = {r[FieldBits-1:0], b};
    if ((t & mtop) != '0) begin
      t = t ^ m;
    end
    return t;
  endfunction

  function automatic logic [ModBits-1:0] top_bit(input logic [ModBits-1:0] m);
    logic [ModBits-1:0] t;
    t = '0;
    for (int i = 0; i < ModBits; i++) begin
      if (m[i]) begin
        t = '0;
        t[i] = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic logic [FieldBits-1:0] reduce(input logic [FieldBits-1:0] x,
                                                  input logic [ModBits-1:0]   m,
                                                  input logic [ModBits-1:0]   mtop);
    logic [ModBits-1:0] r;
    r = '0;
    for (int i = FieldBits - 1; i >= 0; i--) begin
      r = red_shift(r, x[i], m, mtop);
    end
    if (m == '0) begin
      r = '0;
    end
    return r[FieldBits-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gpdr_ram.sv =====
`default_nettype none

module gpdr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpdr_mul.sv =====
`default_nettype none

module gpdr_mul
  import gpdr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [FieldBits-1:0] a_i,
  input  wire logic [FieldBits-1:0] b_i,
  input  wire logic [ModBits-1:0]   mod_i,
  input  wire logic [ModBits-1:0]   mtop_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic      [FieldBits-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(FieldBits + 1);

  logic [CntW-1:0]      cnt_q;
  logic                 done_q;
  logic [FieldBits-1:0] a_q, b_q;
  logic [ModBits-1:0]   p_q, p_d;

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign prod_o = p_q[FieldBits-1:0];

  always_comb begin
    p_d = red_shift(p_q, 1'b0, mod_i, mtop_i);
    if (b_q[FieldBits-1]) begin
      p_d = p_d ^ {1'b0, a_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_o && (cnt_q == CntW'(1));
      if (start_i) begin
        cnt_q <= CntW'(FieldBits);
      end else if (busy_o) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_o) begin
      b_q <= {b_q[FieldBits-2:0], 1'b0};
      p_q <= p_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gf2m_poly_divide_rem_top.sv =====
// Polynomial division with remainder over GF(2^n), the field set by the modulus register.
// The input channel takes one beat per coefficient pair, lowest degree first; a beat with
// last set closes the operand set and starts the division. Beats beyond MAX_COEFFS are
// dropped and flag overflow.
// The configuration channel is always ready and writes the field modulus; it must be
// written only while the block is idle, which the block itself does not enforce.
// After the last beat the block checks degrees, searches the divisor leader's inverse and
// runs the long division on one shared bit-serial multiplier.
// The inverse search costs up to 255 products; each quotient coefficient costs one
// product plus one product per divisor coefficient.
// Results then stream one beat per loaded index, each read from the stores before it is
// offered; while the receiver stalls the current beat is held and nothing else moves.
// Input is not taken from the last beat until the final result beat is accepted.
// Reset clears the control state and sets the modulus to 0x11D; stores need no clearing.
`default_nettype none

module gf2m_poly_divide_rem_top
  import gpdr_pkg::*;
#(
  parameter int unsigned MAX_COEFFS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_beat_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_beat_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [ModBits-1:0]   cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_COEFFS);
  localparam int unsigned CW = $clog2(MAX_COEFFS + 1);

  state_e               state_q, state_d;
  logic [ModBits-1:0]   mod_q, mtop_q;
  logic [CW-1:0]        cnt_q;
  logic                 ovf_q, dval_q, vval_q, divided_q;
  logic [IW-1:0]        ddeg_q, vdeg_q, shift_q, i_q, k_q;
  logic [FieldBits-1:0] vlead_q, qmul_q, remv_q;
  logic [ModBits-1:0]   cand_q;
  status_e              status_q;

  logic                 in_fire, store_en, mul_start, mul_busy, mul_done, found, fail, bad;
  logic [FieldBits-1:0] dv, vs, mul_a, mul_b, prod, rem_rd, div_rd, quot_rd;
  logic                 rem_we, quot_we;
  logic [IW-1:0]        rem_waddr, rem_raddr, qdeg;
  logic [FieldBits-1:0] rem_wdata;
  logic [IW+IdxBits-1:0] k_ext;

  assign cfg_ready_o = 1'b1;
  assign in_fire  = in_valid_i && in_ready_o;
  assign store_en = in_fire && (cnt_q < CW'(MAX_COEFFS));
  assign dv = reduce(in_data_i.dividend_coeff, mod_q, mtop_q);
  assign vs = reduce(in_data_i.divisor_coeff, mod_q, mtop_q);
  assign found = mul_done && (prod == FieldBits'(1));
  assign fail  = mul_done && !found && ((cand_q + ModBits'(1)) == mtop_q);
  assign qdeg  = ddeg_q - vdeg_q;
  assign bad   = (status_q == ST_DIV_ZERO) || (status_q == ST_NOT_INV);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:  if (in_fire && in_data_i.last) state_d = S_CHECK;
      S_CHECK: begin
        if (!vval_q || !dval_q || (ddeg_q < vdeg_q)) state_d = S_ORD;
        else state_d = S_INV;
      end
      S_INV: begin
        if (found) state_d = S_QRD;
        else if (fail) state_d = S_ORD;
      end
      S_QRD:   state_d = S_QST;
      S_QST:   state_d = S_QMUL;
      S_QMUL:  if (mul_done) state_d = S_RRD;
      S_RRD:   state_d = S_RST;
      S_RST:   state_d = S_RMUL;
      S_RMUL: begin
        if (mul_done) begin
          if (i_q != vdeg_q) state_d = S_RRD;
          else if (shift_q == '0) state_d = S_ORD;
          else state_d = S_QRD;
        end
      end
      S_ORD:   state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) state_d = out_data_o.last_out ? S_LOAD : S_ORD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_LOAD);
    out_valid_o = (state_q == S_OUT);
    mul_start   = 1'b0;
    mul_a       = vlead_q;
    mul_b       = FieldBits'(1);
    rem_we      = store_en;
    rem_waddr   = cnt_q[IW-1:0];
    rem_wdata   = dv;
    rem_raddr   = k_q;
    quot_we     = 1'b0;
    case (state_q)
      S_CHECK: mul_start = vval_q && dval_q && (ddeg_q >= vdeg_q);
      S_INV: begin
        mul_start = mul_done && !found && !fail;
        mul_b     = cand_q[FieldBits-1:0] + FieldBits'(1);
      end
      S_QRD:   rem_raddr = shift_q + vdeg_q;
      S_QST: begin
        mul_start = 1'b1;
        mul_a     = rem_rd;
        mul_b     = cand_q[FieldBits-1:0];
      end
      S_QMUL:  quot_we = mul_done;
      S_RRD:   rem_raddr = shift_q + i_q;
      S_RST: begin
        mul_start = 1'b1;
        mul_a     = qmul_q;
        mul_b     = div_rd;
      end
      S_RMUL: begin
        rem_we    = mul_done;
        rem_waddr = shift_q + i_q;
        rem_wdata = remv_q ^ prod;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      mod_q     <= ModBits'(285);
      mtop_q    <= top_bit(ModBits'(285));
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      dval_q    <= 1'b0;
      vval_q    <= 1'b0;
      divided_q <= 1'b0;
      status_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        mod_q  <= cfg_data_i;
        mtop_q <= top_bit(cfg_data_i);
      end
      case (state_q)
        S_LOAD: begin
          divided_q <= 1'b0;
          if (store_en) begin
            cnt_q <= cnt_q + CW'(1);
            if (dv != '0) dval_q <= 1'b1;
            if (vs != '0) vval_q <= 1'b1;
          end else if (in_fire) begin
            ovf_q <= 1'b1;
          end
        end
        S_CHECK: status_q <= !vval_q ? ST_DIV_ZERO : (ovf_q ? ST_OVERFLOW : ST_OK);
        S_INV: begin
          if (found) divided_q <= 1'b1;
          if (fail) status_q <= ST_NOT_INV;
        end
        S_OUT: begin
          if (out_ready_i && out_data_o.last_out) begin
            cnt_q  <= '0;
            ovf_q  <= 1'b0;
            dval_q <= 1'b0;
            vval_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_LOAD: begin
        if (store_en && (dv != '0)) ddeg_q <= cnt_q[IW-1:0];
        if (store_en && (vs != '0)) begin
          vdeg_q  <= cnt_q[IW-1:0];
          vlead_q <= vs;
        end
      end
      S_CHECK: begin
        cand_q  <= ModBits'(1);
        shift_q <= qdeg;
        k_q     <= '0;
      end
      S_INV:  if (mul_done && !found) cand_q <= cand_q + ModBits'(1);
      S_QMUL: begin
        qmul_q <= prod;
        i_q    <= '0;
      end
      S_RST:  remv_q <= rem_rd;
      S_RMUL: begin
        if (mul_done) begin
          i_q <= i_q + IW'(1);
          if (i_q == vdeg_q) begin
            shift_q <= shift_q - IW'(1);
          end
        end
      end
      S_OUT:  if (out_ready_i) k_q <= k_q + IW'(1);
      default: ;
    endcase
  end

  gpdr_ram #(.Width(FieldBits), .Depth(MAX_COEFFS)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (rem_raddr),
    .rdata_o (rem_rd)
  );

  gpdr_ram #(.Width(FieldBits), .Depth(MAX_COEFFS)) u_div_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (vs),
    .raddr_i (i_q),
    .rdata_o (div_rd)
  );

  gpdr_ram #(.Width(FieldBits), .Depth(MAX_COEFFS)) u_quot_ram (
    .clk_i   (clk_i),
    .we_i    (quot_we),
    .waddr_i (shift_q),
    .wdata_i (prod),
    .raddr_i (k_q),
    .rdata_o (quot_rd)
  );

  gpdr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .mod_i   (mod_q),
    .mtop_i  (mtop_q),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign k_ext = {{IdxBits{1'b0}}, k_q};

  always_comb begin
    out_data_o.coeff_index = k_ext[IdxBits-1:0];
    out_data_o.quot_coeff  = (!bad && divided_q && (k_q <= qdeg)) ? quot_rd : '0;
    out_data_o.rem_coeff   = bad ? '0 : rem_rd;
    out_data_o.status      = status_q;
    out_data_o.last_out    = ((CW'(k_q) + CW'(1)) == cnt_q);
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input and result channels active together");

  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last) |=> !in_ready_o)
    else $error("input taken after closing beat");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad) |-> (out_data_o.quot_coeff == '0 && out_data_o.rem_coeff == '0))
    else $error("error beat carries coefficients");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
  import gpdr_pkg::*;

  localparam int unsigned NumCoeffs = 32;
  localparam int unsigned WatchLimit = 200000;

  typedef struct {
    logic [8:0] modulus;
    logic [7:0] dividend;
    logic [7:0] divisor;
    logic       last;
    bit         typed;
    status_e    want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ModBits-1:0] cfg_data_i = '0;

  gf2m_poly_divide_rem_top #(.MAX_COEFFS(NumCoeffs)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [8:0] field_mod;
  logic [7:0] rem_coeffs [NumCoeffs];
  logic [7:0] div_coeffs [NumCoeffs];
  int unsigned pairs_held;
  bit pairs_dropped;
  out_beat_t quot_rem_due[$];

  int unsigned errors;
  int unsigned results_seen;
  int unsigned runs_sent;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  task automatic report(input string what);
    errors++;
    $display("tb: mismatch at %0t: %s", $time, what);
  endtask

  function automatic int poly_deg(input logic [31:0] v);
    int d;
    d = -1;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        d = i;
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] fold(input logic [31:0] x);
    int d;
    d = poly_deg({23'd0, field_mod});
    if (d < 1) begin
      return '0;
    end
    for (int i = 31; i >= d; i--) begin
      if (x[i]) begin
        x = x ^ ({23'd0, field_mod} << (i - d));
      end
    end
    return x[7:0];
  endfunction

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [31:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        p = p ^ ({24'd0, a} << i);
      end
    end
    return fold(p);
  endfunction

  function automatic bit finv(input logic [7:0] a, output logic [7:0] r);
    int d;
    d = poly_deg({23'd0, field_mod});
    r = '0;
    if (d < 1 || a == '0) begin
      return 1'b0;
    end
    for (int b = 1; b < (1 << d); b++) begin
      if (fmul(a, b[7:0]) == 8'd1) begin
        r = b[7:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Loads one coefficient pair; on the last pair divides and queues the results.
  function automatic status_e load_pair(input in_beat_t b);
    logic [7:0] quot [NumCoeffs];
    logic [7:0] inv, m;
    int ddeg, vdeg, n;
    status_e st;
    out_beat_t o;
    ddeg = -1;
    vdeg = -1;
    st = ST_OK;
    if (pairs_held < NumCoeffs) begin
      rem_coeffs[pairs_held] = fold({24'd0, b.dividend_coeff});
      div_coeffs[pairs_held] = fold({24'd0, b.divisor_coeff});
      pairs_held++;
    end else begin
      pairs_dropped = 1'b1;
    end
    if (!b.last) begin
      return st;
    end
    n = pairs_held;
    for (int k = 0; k < n; k++) begin
      quot[k] = '0;
      if (rem_coeffs[k] != '0) ddeg = k;
      if (div_coeffs[k] != '0) vdeg = k;
    end
    if (pairs_dropped) st = ST_OVERFLOW;
    if (vdeg < 0) begin
      st = ST_DIV_ZERO;
    end else if (ddeg >= vdeg) begin
      if (!finv(div_coeffs[vdeg], inv)) begin
        st = ST_NOT_INV;
      end else begin
        for (int s = ddeg - vdeg; s >= 0; s--) begin
          m = fmul(rem_coeffs[s + vdeg], inv);
          quot[s] = m;
          for (int i = 0; i <= vdeg; i++) begin
            rem_coeffs[s + i] = rem_coeffs[s + i] ^ fmul(m, div_coeffs[i]);
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      o.coeff_index = k[IdxBits-1:0];
      o.quot_coeff = (st == ST_DIV_ZERO || st == ST_NOT_INV) ? '0 : quot[k];
      o.rem_coeff = (st == ST_DIV_ZERO || st == ST_NOT_INV) ? '0 : rem_coeffs[k];
      o.status = st;
      o.last_out = (k + 1 == n);
      quot_rem_due.push_back(o);
    end
    pairs_held = 0;
    pairs_dropped = 1'b0;
    return st;
  endfunction

  task automatic send_pair(input in_beat_t b);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    while (quot_rem_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [8:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    field_mod = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_checked(input in_beat_t b);
    send_pair(b);
    void'(load_pair(b));
    if (b.last) runs_sent++;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (quot_rem_due.size() == 0) begin
        report($sformatf("unexpected result beat index %0d", out_data_o.coeff_index));
      end else begin
        e = quot_rem_due.pop_front();
        if (out_data_o.coeff_index != e.coeff_index)
          report($sformatf("index %0d, want %0d", out_data_o.coeff_index, e.coeff_index));
        if (out_data_o.quot_coeff != e.quot_coeff)
          report($sformatf("quotient[%0d] %0h, want %0h", e.coeff_index,
                           out_data_o.quot_coeff, e.quot_coeff));
        if (out_data_o.rem_coeff != e.rem_coeff)
          report($sformatf("remainder[%0d] %0h, want %0h", e.coeff_index,
                           out_data_o.rem_coeff, e.rem_coeff));
        if (out_data_o.status != e.status)
          report($sformatf("status[%0d] %s, want %s", e.coeff_index,
                           out_data_o.status.name(), e.status.name()));
        if (out_data_o.last_out != e.last_out)
          report($sformatf("last flag[%0d] %0b, want %0b", e.coeff_index,
                           out_data_o.last_out, e.last_out));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("tb: timeout with %0d results outstanding", quot_rem_due.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  row_t plan [] = '{
    '{9'd285, 8'd0,   8'd0,   1'b1, 1'b1, ST_DIV_ZERO},
    '{9'd285, 8'd5,   8'd3,   1'b1, 1'b0, ST_OK},
    '{9'd285, 8'd255, 8'd0,   1'b0, 1'b0, ST_OK},
    '{9'd285, 8'd1,   8'd255, 1'b1, 1'b0, ST_OK},
    '{9'd285, 8'd7,   8'd0,   1'b0, 1'b0, ST_OK},
    '{9'd285, 8'd0,   8'd9,   1'b1, 1'b0, ST_OK},
    '{9'd285, 8'd0,   8'd0,   1'b0, 1'b0, ST_OK},
    '{9'd285, 8'd0,   8'd128, 1'b1, 1'b0, ST_OK},
    '{9'd256, 8'd1,   8'd0,   1'b0, 1'b0, ST_OK},
    '{9'd256, 8'd3,   8'd2,   1'b1, 1'b1, ST_NOT_INV},
    '{9'd1,   8'd255, 8'd255, 1'b1, 1'b1, ST_DIV_ZERO},
    '{9'd0,   8'd17,  8'd99,  1'b1, 1'b1, ST_DIV_ZERO},
    '{9'd511, 8'd200, 8'd100, 1'b0, 1'b0, ST_OK},
    '{9'd511, 8'd17,  8'd3,   1'b1, 1'b0, ST_OK},
    '{9'd3,   8'd1,   8'd1,   1'b1, 1'b1, ST_OK},
    '{9'd3,   8'd254, 8'd255, 1'b1, 1'b1, ST_DIV_ZERO}
  };

  initial begin
    in_beat_t b;
    int unsigned len, pick;
    logic [8:0] phase_mod [4];
    errors = 0;
    results_seen = 0;
    runs_sent = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    field_mod = 9'd285;
    pairs_held = 0;
    pairs_dropped = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].modulus != field_mod) write_modulus(plan[r].modulus);
      b.dividend_coeff = plan[r].dividend;
      b.divisor_coeff = plan[r].divisor;
      b.last = plan[r].last;
      send_pair(b);
      void'(load_pair(b));
      if (b.last) runs_sent++;
      // Status of the error rows is written out; the predicted beats take it.
      if (plan[r].typed && b.last) begin
        foreach (quot_rem_due[k]) begin
          quot_rem_due[k].status = plan[r].want;
          if (plan[r].want inside {ST_DIV_ZERO, ST_NOT_INV}) begin
            quot_rem_due[k].quot_coeff = '0;
            quot_rem_due[k].rem_coeff = '0;
          end
        end
      end
    end

    phase_mod = '{9'd285, 9'd256, 9'd511, 9'($urandom_range(2, 511))};
    for (int p = 0; p < 4; p++) begin
      write_modulus(phase_mod[p]);
      send_idle_pct = (p == 1) ? 82 : (p == 3) ? 38 : 0;
      recv_stall_pct = (p == 2) ? 82 : (p == 3) ? 38 : 0;
      for (int sent = 0; sent < 108; sent += len) begin
        pick = $urandom_range(0, 99);
        len = (pick < 80) ? $urandom_range(1, 6) :
              (pick < 95) ? $urandom_range(7, 32) : $urandom_range(33, 36);
        for (int i = 0; i < len; i++) begin
          b.dividend_coeff = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
          b.divisor_coeff = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
          b.last = (i == len - 1);
          send_checked(b);
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain();
    $display("tb: %0d division runs over several field moduli, %0d result beats checked",
             runs_sent, results_seen);
    $display("tb: idle and stall phases covered on both channels");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/gpdr_pkg.sv
rtl/core/gpdr_ram.sv
rtl/core/gpdr_mul.sv
rtl/core/gf2m_poly_divide_rem_top.sv
dv/tb.sv
